// ===== design/fau_pkg.sv =====
// fau_pkg: widths, action codes and unit status type for the fraction unit
// no dependencies; used by every module in the design folder

package fau_pkg;

  // operand width of each numerator and denominator
  localparam int OPND_W = 16;
  // magnitude width of products and their sums
  localparam int MAG_W = 2 * OPND_W;
  // result field widths
  localparam int NUM_W = 33;
  localparam int DEN_W = 31;
  // working widths for wrapping results into the output fields
  localparam int NUM_EXT_W = (MAG_W > NUM_W) ? MAG_W : NUM_W;
  localparam int DEN_EXT_W = (MAG_W > DEN_W) ? MAG_W : DEN_W;
  // iteration counter width, holds MAG_W itself
  localparam int CNT_W = $clog2(MAG_W + 1);

  typedef enum logic [1:0] {
    ActAdd = 2'd0,
    ActSub = 2'd1,
    ActMul = 2'd2,
    ActDiv = 2'd3
  } action_e;

  // status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== design/fau_mul.sv =====
// fau_mul: shared signed operand multiplier with registered product
// depends on fau_pkg

module fau_mul (
  input  logic                                 clk_i,
  input  logic signed [fau_pkg::OPND_W-1:0]    op_a_i,
  input  logic signed [fau_pkg::OPND_W-1:0]    op_b_i,
  output logic        [fau_pkg::MAG_W-1:0]     prod_o
);

  logic signed [fau_pkg::MAG_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= op_a_i * op_b_i;
  end

  assign prod_o = prod_q;

endmodule

// ===== design/fau_gcd.sv =====
// fau_gcd: binary gcd of two nonzero magnitudes, one step per cycle
// depends on fau_pkg

module fau_gcd (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [fau_pkg::MAG_W-1:0]       a_i,
  input  logic [fau_pkg::MAG_W-1:0]       b_i,
  output logic [fau_pkg::MAG_W-1:0]       gcd_o,
  output fau_pkg::unit_stat_t             stat_o
);

  logic [fau_pkg::MAG_W-1:0] u_q, v_q, gcd_q;
  logic [fau_pkg::CNT_W-1:0] k_q;
  logic                      busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q    <= '0;
      v_q    <= '0;
      gcd_q  <= '0;
      k_q    <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        u_q    <= a_i;
        v_q    <= b_i;
        k_q    <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (u_q == v_q) begin
          gcd_q  <= u_q << k_q;
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else if (!u_q[0] && !v_q[0]) begin
          // common factor of two
          u_q <= u_q >> 1;
          v_q <= v_q >> 1;
          k_q <= k_q + 1'b1;
        end else if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (u_q > v_q) begin
          u_q <= (u_q - v_q) >> 1;
        end else begin
          v_q <= (v_q - u_q) >> 1;
        end
      end
    end
  end

  assign gcd_o       = gcd_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  // a zero operand would never converge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (u_q != '0) && (v_q != '0))
    else $error("gcd operand reached zero");

endmodule

// ===== design/fau_div.sv =====
// fau_div: restoring divider, one quotient bit per cycle
// depends on fau_pkg

module fau_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [fau_pkg::MAG_W-1:0]       dividend_i,
  input  logic [fau_pkg::MAG_W-1:0]       divisor_i,
  output logic [fau_pkg::MAG_W-1:0]       quot_o,
  output fau_pkg::unit_stat_t             stat_o
);

  localparam int MagW = fau_pkg::MAG_W;
  localparam int CntW = fau_pkg::CNT_W;

  logic [MagW:0]   rem_q;
  logic [MagW-1:0] quo_q, dsr_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;

  logic [MagW:0]   shifted, rem_d;
  logic            fits;

  always_comb begin
    shifted = {rem_q[MagW-1:0], quo_q[MagW-1]};
    fits    = shifted >= {1'b0, dsr_q};
    rem_d   = fits ? (shifted - {1'b0, dsr_q}) : shifted;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      dsr_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= '0;
        quo_q  <= dividend_i;
        dsr_q  <= divisor_i;
        cnt_q  <= CntW'(MagW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= {quo_q[MagW-2:0], fits};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quot_o      = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> dsr_q != '0)
    else $error("divider running with zero divisor");

endmodule

// ===== design/fraction_arithmetic_unit.sv =====
// fraction_arithmetic_unit: top level, sequencer around the shared units
// depends on fau_pkg, fau_mul, fau_gcd, fau_div
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid_i, in_ready_o, action_i, left_num_i,  | to block
//           | left_den_i, right_num_i, right_den_i           |
//   out     | out_valid_o, out_ready_i, result_num_o,        | from block
//           | result_den_o, error_o                          |
//
// one item at a time: the multiplier states StMulA to StMulD, the check
// state, the binary gcd (a subtract/shift loop), then two divisions on
// the shared divider
// an error or a zero numerator skips gcd and division
// in_ready_o is high only while idle; a result waits in the output register
// while the next item is already accepted and worked on
// reset is asynchronous, active low, and leaves the block idle and empty

module fraction_arithmetic_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          action_i,
  input  logic signed [fau_pkg::OPND_W-1:0]   left_num_i,
  input  logic signed [fau_pkg::OPND_W-1:0]   left_den_i,
  input  logic signed [fau_pkg::OPND_W-1:0]   right_num_i,
  input  logic signed [fau_pkg::OPND_W-1:0]   right_den_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [fau_pkg::NUM_W-1:0]    result_num_o,
  output logic        [fau_pkg::DEN_W-1:0]    result_den_o,
  output logic                                error_o
);

  localparam int MagW    = fau_pkg::MAG_W;
  localparam int NumExtW = fau_pkg::NUM_EXT_W;
  localparam int DenExtW = fau_pkg::DEN_EXT_W;

  typedef enum logic [3:0] {
    StIdle,
    StMulA,
    StMulB,
    StMulC,
    StMulD,
    StCheck,
    StGcd,
    StDivNum,
    StDivDen,
    StFinish
  } state_e;

  state_e state_q;

  // captured operands
  fau_pkg::action_e                  action_q;
  logic signed [fau_pkg::OPND_W-1:0] left_num_q, left_den_q, right_num_q, right_den_q;

  // cross products, numerator one bit wider for the sum
  logic [MagW:0]   num_q;
  logic [MagW-1:0] den_q;
  logic [MagW-1:0] num_mag_q, den_mag_q;
  logic [MagW-1:0] res_mag_q, res_den_q;
  logic            res_neg_q, res_err_q;

  logic                              in_accept;
  logic signed [fau_pkg::OPND_W-1:0] mul_a, mul_b;
  logic [MagW-1:0]                   prod;
  logic [MagW:0]                     prod_ext, num_abs;
  logic [MagW-1:0]                   den_abs;
  logic                              bad_den, zero_num;

  logic                gcd_start, div_start;
  logic [MagW-1:0]     gcd_val, div_dividend, quot;
  fau_pkg::unit_stat_t gcd_stat, div_stat;

  logic [NumExtW-1:0] num_ext, num_signed;
  logic [DenExtW-1:0] den_ext;

  assign in_ready_o = (state_q == StIdle);
  assign in_accept  = in_valid_i && in_ready_o;

  // operand select for the shared multiplier, one product per state
  always_comb begin
    case (state_q)
      StMulA: begin
        // first numerator term: a*c for multiply, a*d otherwise
        mul_a = left_num_q;
        mul_b = (action_q == fau_pkg::ActMul) ? right_num_q : right_den_q;
      end
      StMulB: begin
        // second numerator term c*b, used by add and subtract
        mul_a = right_num_q;
        mul_b = left_den_q;
      end
      default: begin
        // denominator: b*c for divide, b*d otherwise
        mul_a = left_den_q;
        mul_b = (action_q == fau_pkg::ActDiv) ? right_num_q : right_den_q;
      end
    endcase
  end

  fau_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  always_comb begin
    prod_ext = {prod[MagW-1], prod};
    num_abs  = num_q[MagW] ? (~num_q + 1'b1) : num_q;
    den_abs  = den_q[MagW-1] ? (~den_q + 1'b1) : den_q;
    bad_den  = (left_den_q == '0) || (right_den_q == '0) || (den_q == '0);
    zero_num = (num_q == '0);
  end

  assign gcd_start    = (state_q == StCheck) && !bad_den && !zero_num;
  assign div_start    = ((state_q == StGcd) && gcd_stat.done) ||
                        ((state_q == StDivNum) && div_stat.done);
  assign div_dividend = (state_q == StGcd) ? num_mag_q : den_mag_q;

  fau_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .a_i     (num_abs[MagW-1:0]),
    .b_i     (den_abs),
    .gcd_o   (gcd_val),
    .stat_o  (gcd_stat)
  );

  fau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (gcd_val),
    .quot_o     (quot),
    .stat_o     (div_stat)
  );

  // sign goes onto the numerator, both wrap to the output widths
  always_comb begin
    num_ext    = NumExtW'(res_mag_q);
    num_signed = res_neg_q ? (~num_ext + 1'b1) : num_ext;
    den_ext    = DenExtW'(res_den_q);
  end

  // operand capture, payload only
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      action_q    <= fau_pkg::action_e'(action_i);
      left_num_q  <= left_num_i;
      left_den_q  <= left_den_i;
      right_num_q <= right_num_i;
      right_den_q <= right_den_i;
    end
  end

  // sequencer with working and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      out_valid_o  <= 1'b0;
      result_num_o <= '0;
      result_den_o <= '0;
      error_o      <= 1'b0;
      num_q        <= '0;
      den_q        <= '0;
      num_mag_q    <= '0;
      den_mag_q    <= '0;
      res_mag_q    <= '0;
      res_den_q    <= '0;
      res_neg_q    <= 1'b0;
      res_err_q    <= 1'b0;
    end else begin
      // the finish state reloads the output register on its own
      if (out_valid_o && out_ready_i && (state_q != StFinish)) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q <= StMulA;
          end
        end
        StMulA: begin
          state_q <= StMulB;
        end
        StMulB: begin
          num_q   <= prod_ext;
          state_q <= StMulC;
        end
        StMulC: begin
          if (action_q == fau_pkg::ActAdd) begin
            num_q <= num_q + prod_ext;
          end else if (action_q == fau_pkg::ActSub) begin
            num_q <= num_q - prod_ext;
          end
          state_q <= StMulD;
        end
        StMulD: begin
          den_q   <= prod;
          state_q <= StCheck;
        end
        StCheck: begin
          if (bad_den) begin
            // zero denominator in an input or after division by zero
            res_mag_q <= '0;
            res_den_q <= '0;
            res_neg_q <= 1'b0;
            res_err_q <= 1'b1;
            state_q   <= StFinish;
          end else if (zero_num) begin
            res_mag_q <= '0;
            res_den_q <= MagW'(1);
            res_neg_q <= 1'b0;
            res_err_q <= 1'b0;
            state_q   <= StFinish;
          end else begin
            num_mag_q <= num_abs[MagW-1:0];
            den_mag_q <= den_abs;
            res_neg_q <= num_q[MagW] ^ den_q[MagW-1];
            res_err_q <= 1'b0;
            state_q   <= StGcd;
          end
        end
        StGcd: begin
          if (gcd_stat.done) begin
            state_q <= StDivNum;
          end
        end
        StDivNum: begin
          if (div_stat.done) begin
            res_mag_q <= quot;
            state_q   <= StDivDen;
          end
        end
        StDivDen: begin
          if (div_stat.done) begin
            res_den_q <= quot;
            state_q   <= StFinish;
          end
        end
        StFinish: begin
          // wait only while the previous result is still held
          if (!out_valid_o || out_ready_i) begin
            result_num_o <= num_signed[fau_pkg::NUM_W-1:0];
            result_den_o <= den_ext[fau_pkg::DEN_W-1:0];
            error_o      <= res_err_q;
            out_valid_o  <= 1'b1;
            state_q      <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // an accepted item keeps the block busy in the cycle after it is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_ready_o)
    else $error("input accepted again right after an item");

  // error results carry zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> (result_den_o == '0) && (result_num_o == '0))
    else $error("error result with nonzero fields");

  // shared units only run in their own sequencer states
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (state_q == StDivNum) || (state_q == StDivDen))
    else $error("divider busy outside division states");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    gcd_stat.busy |-> state_q == StGcd)
    else $error("gcd busy outside gcd state");

endmodule

// ===== tb/sv/fraction_arithmetic_unit_tb.sv =====
// fraction_arithmetic_unit_tb: self-checking bench for the fraction arithmetic unit
// depends on fau_pkg and fraction_arithmetic_unit; predicts each reduced fraction
// and checks it field by field against the unit's output
`timescale 1ns / 100ps

module fraction_arithmetic_unit_tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 800;
  localparam int TAIL_CYCLES = 200;
  localparam int PHASE_ITEMS = 220;

  typedef logic signed [fau_pkg::OPND_W-1:0] operand_t;

  typedef struct packed {
    logic [fau_pkg::NUM_W-1:0] num;
    logic [fau_pkg::DEN_W-1:0] den;
    logic                      err;
  } fraction_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                in_action = 2'b00;
  operand_t                  left_num = '0;
  operand_t                  left_den = '0;
  operand_t                  right_num = '0;
  operand_t                  right_den = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [fau_pkg::NUM_W-1:0] result_num;
  logic [fau_pkg::DEN_W-1:0] result_den;
  logic                      result_error;

  fraction_t pending_results[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        hold_request = 1'b0;

  fraction_arithmetic_unit u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .action_i     (in_action),
    .left_num_i   (left_num),
    .left_den_i   (left_den),
    .right_num_i  (right_num),
    .right_den_i  (right_den),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .result_num_o (result_num),
    .result_den_o (result_den),
    .error_o      (result_error)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // exact result of the operation: cross products, sign onto the numerator,
  // reduction by the gcd of the magnitudes, wrap to the output widths
  function automatic fraction_t exact_fraction_result(fau_pkg::action_e act,
                                                      operand_t ln, operand_t ld,
                                                      operand_t rn, operand_t rd);
    longint          a, b, c, d, num, den;
    longint unsigned mag_num, mag_den, x, y, r;
    bit              neg;
    fraction_t       res;
    a = longint'(ln);
    b = longint'(ld);
    c = longint'(rn);
    d = longint'(rd);
    res.num = '0;
    res.den = '0;
    res.err = 1'b1;
    if (b == 0 || d == 0) return res;
    case (act)
      fau_pkg::ActAdd: begin
        num = a * d + c * b;
        den = b * d;
      end
      fau_pkg::ActSub: begin
        num = a * d - c * b;
        den = b * d;
      end
      fau_pkg::ActMul: begin
        num = a * c;
        den = b * d;
      end
      default: begin
        num = a * d;
        den = b * c;
      end
    endcase
    // dividing by a zero fraction
    if (den == 0) return res;
    res.err = 1'b0;
    if (num == 0) begin
      res.den[0] = 1'b1;
      return res;
    end
    neg = (num < 0) != (den < 0);
    mag_num = (num < 0) ? -num : num;
    mag_den = (den < 0) ? -den : den;
    x = mag_num;
    y = mag_den;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    mag_num = mag_num / x;
    mag_den = mag_den / x;
    if (neg) mag_num = -mag_num;
    res.num = mag_num[fau_pkg::NUM_W-1:0];
    res.den = mag_den[fau_pkg::DEN_W-1:0];
    return res;
  endfunction

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic flag_mismatch(input string field, input longint expd, input longint got);
    $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, field, expd, got);
    mismatch_count++;
  endtask

  // result check: every accepted item is compared with the oldest prediction
  always @(posedge clk) begin : result_check
    fraction_t expd;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected item num", 0, longint'($signed(result_num)));
      end else begin
        expd = pending_results.pop_front();
        if (result_num !== expd.num)
          flag_mismatch("result_num", longint'($signed(expd.num)),
                        longint'($signed(result_num)));
        if (result_den !== expd.den)
          flag_mismatch("result_den", longint'(expd.den), longint'(result_den));
        if (result_error !== expd.err)
          flag_mismatch("error", longint'(expd.err), longint'(result_error));
      end
    end
  end

  // offer one item and return at the edge where it is accepted; valid stays
  // high so a following call can chain items without a bubble
  task automatic send_item(input fau_pkg::action_e act, input int ln, input int ld,
                           input int rn, input int rd);
    int gap;
    gap = 0;
    if (send_idle_pct != 0) begin
      if ($urandom_range(19) == 0) gap = $urandom_range(1, 200);
      else while ($urandom_range(99) < send_idle_pct) gap++;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    left_num  <= operand_t'(ln);
    left_den  <= operand_t'(ld);
    right_num <= operand_t'(rn);
    right_den <= operand_t'(rd);
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(exact_fraction_result(act, operand_t'(ln), operand_t'(ld),
                                                    operand_t'(rn), operand_t'(rd)));
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_all_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // mix of full-range values, small values, extremes, powers of two and
  // multiples of a shared factor so that the gcd has real work to do
  function automatic int pick_operand(int factor, bit is_den);
    int sel;
    int v;
    sel = $urandom_range(99);
    if (is_den && sel < 3) return 0;
    if (factor > 1) begin
      v = factor * $urandom_range(0, 32767 / factor);
    end else if (sel < 40) begin
      return int'(operand_t'($urandom()));
    end else if (sel < 65) begin
      v = $urandom_range(0, 40) - 20;
    end else if (sel < 80) begin
      case ($urandom_range(4))
        0: v = -32768;
        1: v = 32767;
        2: v = -32767;
        3: v = -1;
        default: v = 1;
      endcase
    end else begin
      v = 1 << $urandom_range(0, 15);
    end
    if ($urandom_range(1) == 1) v = -v;
    return int'(operand_t'(v));
  endfunction

  task automatic send_random_item();
    fau_pkg::action_e act;
    int               factor;
    act = fau_pkg::action_e'($urandom_range(3));
    factor = ($urandom_range(9) < 3) ? $urandom_range(2, 300) : 1;
    send_item(act, pick_operand(factor, 1'b0), pick_operand(factor, 1'b1),
              pick_operand(factor, 1'b0), pick_operand(factor, 1'b1));
  endtask

  task automatic apply_reset();
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_item(fau_pkg::ActAdd, 1, 2, 1, 3);
    send_item(fau_pkg::ActSub, 1, 2, 1, 3);
    send_item(fau_pkg::ActMul, 2, 3, 3, 4);
    send_item(fau_pkg::ActDiv, 2, 3, 4, 9);
    // extreme magnitudes
    send_item(fau_pkg::ActAdd, -32768, -32768, -32768, -32768);
    send_item(fau_pkg::ActAdd, 32767, -32768, -32768, 32767);
    send_item(fau_pkg::ActSub, -32768, 1, 32767, 1);
    send_item(fau_pkg::ActSub, -32768, 32767, 32767, -32768);
    send_item(fau_pkg::ActMul, -32768, 1, -32768, 1);
    send_item(fau_pkg::ActMul, 1, -32768, 1, 32767);
    send_item(fau_pkg::ActDiv, -32768, 1, 1, -32768);
    send_item(fau_pkg::ActDiv, 32767, -32768, -32768, 32767);
    // zero denominator on either side
    send_item(fau_pkg::ActAdd, 5, 0, 3, 7);
    send_item(fau_pkg::ActSub, 5, 7, 3, 0);
    send_item(fau_pkg::ActDiv, 0, 0, 0, 0);
    // division by a zero fraction, also with a zero numerator
    send_item(fau_pkg::ActDiv, 3, 4, 0, 5);
    send_item(fau_pkg::ActDiv, 0, 3, 0, 5);
    // zero numerator, direct and by cancellation
    send_item(fau_pkg::ActMul, 0, 5, 3, 7);
    send_item(fau_pkg::ActAdd, 1, 2, -1, 2);
    send_item(fau_pkg::ActSub, -1, -1, -1, -1);
    // negative denominators and coprime values
    send_item(fau_pkg::ActMul, 3, -4, -5, -6);
    send_item(fau_pkg::ActAdd, 32749, 32719, 32713, 32707);
    send_item(fau_pkg::ActAdd, 32767, 32767, 32767, 32767);
    release_input();
    wait_all_results();
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (PHASE_ITEMS) send_random_item();
    release_input();
    wait_all_results();
  endtask

  task automatic test_back_to_back();
    run_random_phase(0, 0);
  endtask

  task automatic test_sender_gaps();
    run_random_phase(53, 0);
  endtask

  task automatic test_receiver_stalls();
    run_random_phase(0, 53);
  endtask

  task automatic test_both_idle();
    run_random_phase(28, 28);
  endtask

  // receiver holds off long enough for the unit to fill and stall its input
  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 1'b1;
    repeat (8) send_random_item();
    release_input();
    wait_all_results();
  endtask

  // short bursts, each drained completely before the next one starts
  task automatic test_burst_drain();
    send_idle_pct = 0;
    recv_stall_pct = 20;
    repeat (10) begin
      repeat ($urandom_range(1, 6)) send_random_item();
      release_input();
      wait_all_results();
    end
  endtask

  initial begin
    apply_reset();
    test_directed_cases();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_output_hold();
    test_burst_drain();
    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
